### rtl/ngga_pkg.sv
package ngga_pkg;

	// Sizes of the sentence buffer and the comma position table.
	localparam int BUF_DEPTH   = 128;
	localparam int BUF_AW      = $clog2(BUF_DEPTH);
	localparam int POS_W       = 8;
	localparam int COMMA_SLOTS = 32;
	localparam int CT_AW       = $clog2(COMMA_SLOTS);
	localparam int CNT_W       = 6;
	localparam int HDR_W       = 24;

	// Characters that the parser recognizes.
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_G      = 8'h47;
	localparam logic [7:0] CH_A      = 8'h41;
	localparam logic [HDR_W-1:0] HDR_GGA = {CH_G, CH_G, CH_A};

	// Operation codes of a request word.
	localparam logic [1:0] OP_RX       = 2'd0;
	localparam logic [1:0] OP_RD_BYTE  = 2'd1;
	localparam logic [1:0] OP_RD_COMMA = 2'd2;

	// Source of read data for a response.
	typedef enum logic [1:0] {
		RD_NONE,
		RD_STORE,
		RD_COMMA
	} rd_sel_t;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] data_byte;
		logic [6:0] read_index;
	} req_word_t;

	typedef struct packed {
		logic             capturing;
		logic             stored;
		logic [POS_W-1:0] store_position;
		logic [CNT_W-1:0] comma_total;
		logic [7:0]       read_data;
		logic             overflow;
		logic             sentence_start;
	} rsp_word_t;

	// Memory access commands from the control logic.
	typedef struct packed {
		logic              st_we;
		logic [BUF_AW-1:0] st_waddr;
		logic [7:0]        st_wdata;
		logic              st_re;
		logic [BUF_AW-1:0] st_raddr;
		logic              ct_we;
		logic [CT_AW-1:0]  ct_waddr;
		logic [BUF_AW-1:0] ct_wdata;
		logic              ct_re;
		logic [CT_AW-1:0]  ct_raddr;
	} mem_ctl_t;

endpackage

### rtl/ngga_mem.sv
module ngga_mem
	import ngga_pkg::*;
(
	input  logic              clk,
	input  mem_ctl_t          ctl,
	output logic [7:0]        rd_store,
	output logic [BUF_AW-1:0] rd_comma
);

	logic [7:0]        st_mem [BUF_DEPTH];
	logic [BUF_AW-1:0] ct_mem [COMMA_SLOTS];
	logic [7:0]        rd_store_q;
	logic [BUF_AW-1:0] rd_comma_q;

	// Sentence buffer: one write and one registered read port.
	always_ff @(posedge clk) begin
		if (ctl.st_we) begin
			st_mem[ctl.st_waddr] <= ctl.st_wdata;
		end
		if (ctl.st_re) begin
			rd_store_q <= st_mem[ctl.st_raddr];
		end
	end

	// Comma position table: one write and one registered read port.
	always_ff @(posedge clk) begin
		if (ctl.ct_we) begin
			ct_mem[ctl.ct_waddr] <= ctl.ct_wdata;
		end
		if (ctl.ct_re) begin
			rd_comma_q <= ct_mem[ctl.ct_raddr];
		end
	end

	assign rd_store = rd_store_q;
	assign rd_comma = rd_comma_q;

endmodule

### rtl/nmea_gga_sentence_capture_core.sv
// Captures the GGA sentence from a stream of received GPS serial bytes and serves
// reads of the stored bytes and comma positions. Every request word gives exactly one
// response word, which passes through the stage one register and the output register.
// A new word can be accepted every cycle while the output is not stalled. The sentence
// buffer and the comma table are synchronous memories with a registered read. A word
// only reads or only writes, and a write lands at its accept edge, so a read that
// follows a write to the same entry always sees the new data. Reads of entries beyond
// the current write position or comma count return zero. No clearing pass is needed
// after reset.
module nmea_gga_sentence_capture_core
	import ngga_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_word_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_word_t rsp
);

	// Sentence state.
	logic [HDR_W-1:0] hdr_q, hdr_d;
	logic             cap_q, cap_d;
	logic [POS_W-1:0] wpos_q, wpos_d;
	logic [CNT_W-1:0] cc_q, cc_d;
	logic             ovf_q, ovf_d;

	logic     acc;
	logic     stored;
	logic     start;
	mem_ctl_t ctl;
	rd_sel_t  rsel;

	// First stage: the updated status and which memory supplies read data.
	logic      valid_s1;
	rsp_word_t word_s1;
	rd_sel_t   rsel_s1;
	logic      adv_s1;

	logic              rsp_valid_q;
	rsp_word_t         rsp_q;
	rsp_word_t         word_out;
	logic [7:0]        rd_store;
	logic [BUF_AW-1:0] rd_comma;
	logic [7:0]        rd_mux;

	assign adv_s1    = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && rsp_valid_q && rsp_stall;
	assign acc       = req_valid && !req_stall;

	// Next-state logic for the parser and the memory commands.
	always_comb begin
		hdr_d  = hdr_q;
		cap_d  = cap_q;
		wpos_d = wpos_q;
		cc_d   = cc_q;
		ovf_d  = ovf_q;
		stored = 1'b0;
		start  = 1'b0;
		ctl    = '0;
		rsel   = RD_NONE;
		ctl.st_waddr = wpos_q[BUF_AW-1:0];
		ctl.st_wdata = req.data_byte;
		ctl.ct_waddr = cc_q[CT_AW-1:0];
		ctl.ct_wdata = wpos_q[BUF_AW-1:0];
		ctl.st_raddr = req.read_index[BUF_AW-1:0];
		ctl.ct_raddr = req.read_index[CT_AW-1:0];
		if (acc) begin
			case (req.op)
				OP_RX: begin
					if (req.data_byte == CH_DOLLAR) begin
						wpos_d = '0;
						cc_d   = '0;
						cap_d  = 1'b0;
						ovf_d  = 1'b0;
						start  = 1'b1;
					end else if (cap_q) begin
						if (!ovf_q) begin
							if (wpos_q == POS_W'(BUF_DEPTH)) begin
								ovf_d = 1'b1;
							end else if (req.data_byte == CH_COMMA &&
								cc_q == CNT_W'(COMMA_SLOTS)) begin
								ovf_d = 1'b1;
							end else begin
								if (req.data_byte == CH_COMMA) begin
									ctl.ct_we = 1'b1;
									cc_d      = cc_q + CNT_W'(1);
								end
								ctl.st_we = 1'b1;
								wpos_d    = wpos_q + POS_W'(1);
								stored    = 1'b1;
							end
						end
					end else if (hdr_q == HDR_GGA) begin
						cap_d = 1'b1;
						hdr_d = '0;
					end else begin
						hdr_d = {hdr_q[HDR_W-9:0], req.data_byte};
					end
				end
				OP_RD_BYTE: begin
					if (POS_W'(req.read_index) < wpos_q) begin
						ctl.st_re = 1'b1;
						rsel      = RD_STORE;
					end
				end
				OP_RD_COMMA: begin
					if (req.read_index < 7'(cc_q)) begin
						ctl.ct_re = 1'b1;
						rsel      = RD_COMMA;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q  <= '0;
			cap_q  <= 1'b0;
			wpos_q <= '0;
			cc_q   <= '0;
			ovf_q  <= 1'b0;
		end else begin
			hdr_q  <= hdr_d;
			cap_q  <= cap_d;
			wpos_q <= wpos_d;
			cc_q   <= cc_d;
			ovf_q  <= ovf_d;
		end
	end

	ngga_mem u_mem (
		.clk      (clk),
		.ctl      (ctl),
		.rd_store (rd_store),
		.rd_comma (rd_comma)
	);

	// Stage one valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage one payload, loaded as the memory read is issued.
	always_ff @(posedge clk) begin
		if (acc) begin
			word_s1.capturing      <= cap_d;
			word_s1.stored         <= stored;
			word_s1.store_position <= wpos_d;
			word_s1.comma_total    <= cc_d;
			word_s1.read_data      <= '0;
			word_s1.overflow       <= ovf_d;
			word_s1.sentence_start <= start;
			rsel_s1                <= rsel;
		end
	end

	// Pick the read data that the memory returned.
	always_comb begin
		case (rsel_s1)
			RD_STORE: rd_mux = rd_store;
			RD_COMMA: rd_mux = 8'(rd_comma);
			default:  rd_mux = '0;
		endcase
	end

	// Stage one word with the read data filled in.
	always_comb begin
		word_out           = word_s1;
		word_out.read_data = rd_mux;
	end

	// Output register that holds a word while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv_s1) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			rsp_q <= word_out;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTH
	// The write position never runs past the end of the buffer.
	a_wpos_range: assert property (@(posedge clk) disable iff (!arst_n)
		wpos_q <= POS_W'(BUF_DEPTH))
		else $error("write position beyond buffer depth");

	// The comma count never runs past the table size.
	a_cc_range: assert property (@(posedge clk) disable iff (!arst_n)
		cc_q <= CNT_W'(COMMA_SLOTS))
		else $error("comma count beyond table size");

	// While capturing, the header window stays cleared.
	a_hdr_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cap_q |-> hdr_q == '0)
		else $error("header window not clear during capture");

	// A stalled stage one blocks new words.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |-> !acc)
		else $error("word accepted over a held stage");
`endif

endmodule
